@@ hw/rtl/tspdf_pkg.sv @@
// Package for the TCP source/port drop filter: action and status codes,
// frame offsets, protocol constants and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package tspdf_pkg;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_PACKET = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Status codes of a table operation
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Byte offsets of captured header fields
    localparam logic [5:0] OFF_ETHERTYPE_HI = 6'd12;
    localparam logic [5:0] OFF_ETHERTYPE_LO = 6'd13;
    localparam logic [5:0] OFF_VERSION      = 6'd14;
    localparam logic [5:0] OFF_PROTOCOL     = 6'd23;
    localparam logic [5:0] OFF_SRC_FIRST    = 6'd26;
    localparam logic [5:0] OFF_SRC_LAST     = 6'd29;
    localparam logic [5:0] OFF_DPORT_HI     = 6'd36;
    localparam logic [5:0] OFF_DPORT_LO     = 6'd37;
    localparam logic [5:0] OFFSET_MAX       = 6'd63;
    localparam logic [5:0] MIN_LAST_OFFSET  = 6'd53;

    // Header values that qualify a frame for the table lookup
    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic [3:0]  IPV4_VERSION   = 4'd4;
    localparam logic [7:0]  TCP_PROTOCOL   = 8'd6;

    localparam int TABLE_ENTRIES_DEFAULT = 128;

    // Captured frame information for the verdict
    typedef struct packed {
        logic        header_ok;
        logic [31:0] src_address;
        logic [15:0] dst_port;
    } frame_info_t;

    // Request to the match table
    typedef struct packed {
        logic        write;
        logic        remove;
        logic [31:0] key;
        logic [15:0] port;
    } tbl_req_t;

    // Response of the match table, valid in the same cycle as the request
    typedef struct packed {
        logic verdict_hit;
        logic key_found;
        logic has_free;
    } tbl_rsp_t;

endpackage

@@ hw/rtl/tspdf_parser.sv @@
// Frame header capture for the drop filter: byte offset counter and the
// ethertype, version, protocol, source address and destination port fields.
// Depends on tspdf_pkg.
`timescale 1ns / 1ps

module tspdf_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_value,
    input  logic                  last_byte,
    output tspdf_pkg::frame_info_t info
);

    logic [5:0]  offset_reg;
    logic [5:0]  offset_next;
    logic [15:0] ethertype_reg;
    logic [15:0] ethertype_next;
    logic [3:0]  version_reg;
    logic [3:0]  version_next;
    logic [7:0]  protocol_reg;
    logic [7:0]  protocol_next;
    logic [31:0] src_reg;
    logic [31:0] src_next;
    logic [15:0] dport_reg;
    logic [15:0] dport_next;

    // Capture the current byte into the field that owns its offset
    always_comb
    begin
        ethertype_next = ethertype_reg;
        version_next   = version_reg;
        protocol_next  = protocol_reg;
        src_next       = src_reg;
        dport_next     = dport_reg;
        offset_next    = offset_reg;
        if (step)
        begin
            case (offset_reg) inside
                tspdf_pkg::OFF_ETHERTYPE_HI, tspdf_pkg::OFF_ETHERTYPE_LO:
                    ethertype_next = {ethertype_reg[7:0], byte_value};
                tspdf_pkg::OFF_VERSION:
                    version_next = byte_value[7:4];
                tspdf_pkg::OFF_PROTOCOL:
                    protocol_next = byte_value;
                [tspdf_pkg::OFF_SRC_FIRST:tspdf_pkg::OFF_SRC_LAST]:
                    src_next = {src_reg[23:0], byte_value};
                tspdf_pkg::OFF_DPORT_HI, tspdf_pkg::OFF_DPORT_LO:
                    dport_next = {dport_reg[7:0], byte_value};
                default:
                    ;
            endcase
            // Clear all frame state after the final byte, else advance the offset, holding it at the maximum
            if (last_byte)
            begin
                offset_next    = '0;
                ethertype_next = '0;
                version_next   = '0;
                protocol_next  = '0;
                src_next       = '0;
                dport_next     = '0;
            end
            else if (offset_reg != tspdf_pkg::OFFSET_MAX)
            begin
                offset_next = offset_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            ethertype_reg <= '0;
            version_reg   <= '0;
            protocol_reg  <= '0;
            src_reg       <= '0;
            dport_reg     <= '0;
        end
        else
        begin
            offset_reg    <= offset_next;
            ethertype_reg <= ethertype_next;
            version_reg   <= version_next;
            protocol_reg  <= protocol_next;
            src_reg       <= src_next;
            dport_reg     <= dport_next;
        end
    end

    // Qualify the frame; the final byte never lands in a captured field
    // once the frame is long enough, so the registered fields are complete
    assign info.header_ok = (offset_reg >= tspdf_pkg::MIN_LAST_OFFSET)
                         && (ethertype_reg == tspdf_pkg::IPV4_ETHERTYPE)
                         && (version_reg == tspdf_pkg::IPV4_VERSION)
                         && (protocol_reg == tspdf_pkg::TCP_PROTOCOL);
    assign info.src_address = src_reg;
    assign info.dst_port    = dport_reg;

endmodule

@@ hw/rtl/tspdf_table.sv @@
// Exact-match table for the drop filter: one cell per entry holding a valid
// bit, a source address key and a port, all compared in parallel.
// Depends on tspdf_pkg.
`timescale 1ns / 1ps

module tspdf_table
#(
    parameter int ENTRIES = tspdf_pkg::TABLE_ENTRIES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tspdf_pkg::tbl_req_t req,
    output tspdf_pkg::tbl_rsp_t rsp
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [31:0]        key_reg  [ENTRIES];
    logic [15:0]        port_reg [ENTRIES];
    logic [ENTRIES-1:0] key_match;
    logic [ENTRIES-1:0] port_match;
    logic [ENTRIES-1:0] free;
    logic [ENTRIES-1:0] first_free;
    logic [ENTRIES-1:0] write_sel;

    // Compare every cell against the request key and port
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_match[i]  = valid_reg[i] && (key_reg[i] == req.key);
            port_match[i] = (port_reg[i] == req.port);
        end
    end

    // Isolate the lowest free cell
    assign free       = ~valid_reg;
    assign first_free = free & (~free + ENTRIES'(1));

    assign rsp.key_found   = |key_match;
    assign rsp.has_free    = |free;
    assign rsp.verdict_hit = |(key_match & port_match);

    // Replace a matching entry, else fill the lowest free cell
    assign write_sel = rsp.key_found ? key_match : first_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.write)
        begin
            valid_next = valid_reg | write_sel;
        end
        else if (req.remove)
        begin
            valid_next = valid_reg & ~key_match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load key and port into the selected cell
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (req.write && write_sel[i])
            begin
                key_reg[i]  <= req.key;
                port_reg[i] <= req.port;
            end
        end
    end

endmodule

@@ hw/rtl/tcp_source_port_drop_filter.sv @@
// TCP source/port drop filter top level: input register, header capture,
// parallel match table and result register.
// Depends on tspdf_pkg, tspdf_parser and tspdf_table.
// Timing: an accepted word sits in the input register; its result loads into the
// result register when the word advances and is held there until taken. Throughput:
// one word per cycle while the result register is not stalled by m_axis_tready,
// using the parallel compare across all table cells.
// Reset: asynchronous; clears frame state and all table valid bits at once.
`timescale 1ns / 1ps

module tcp_source_port_drop_filter
#(
    parameter int TABLE_ENTRIES = tspdf_pkg::TABLE_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // byte_value[7:0], entry_address[39:8], entry_port[55:40]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // drop[0], status[2:1], zero[7:3]
    output logic [0:0]  m_axis_tuser   // is_verdict[0]
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  in_action_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [31:0] in_addr_reg;
    logic [15:0] in_port_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_verdict_reg;
    logic        out_verdict_next;
    logic        out_drop_reg;
    logic        out_drop_next;
    logic [1:0]  out_status_reg;
    logic [1:0]  out_status_next;

    logic        is_packet;
    logic        is_write;
    logic        is_remove;
    logic        has_result;
    logic        advance;
    logic        s_accept;

    tspdf_pkg::frame_info_t info;
    tspdf_pkg::tbl_req_t    req;
    tspdf_pkg::tbl_rsp_t    rsp;

    // Decode the held word
    assign is_packet  = (in_action_reg == tspdf_pkg::ACT_PACKET);
    assign is_write   = (in_action_reg == tspdf_pkg::ACT_WRITE);
    assign is_remove  = (in_action_reg == tspdf_pkg::ACT_REMOVE);
    assign has_result = (is_packet && in_last_reg) || is_write || is_remove;

    // Advance when the word makes no result or the result register frees up
    assign advance       = in_valid_reg && (!has_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Hold the input word
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_action_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata[7:0];
            in_last_reg   <= s_axis_tlast;
            in_addr_reg   <= s_axis_tdata[39:8];
            in_port_reg   <= s_axis_tdata[55:40];
        end
    end

    tspdf_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance && is_packet),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .info       (info)
    );

    // Share the cell comparators between frame lookup and table updates
    always_comb
    begin
        req.write  = advance && is_write;
        req.remove = advance && is_remove;
        req.key    = is_packet ? info.src_address : in_addr_reg;
        req.port   = is_packet ? info.dst_port : in_port_reg;
    end

    tspdf_table #(.ENTRIES(TABLE_ENTRIES)) u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Form the result word
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;
        out_drop_next    = out_drop_reg;
        out_status_next  = out_status_reg;
        if (advance && has_result)
        begin
            out_valid_next   = 1'b1;
            out_verdict_next = is_packet;
            out_drop_next    = is_packet && info.header_ok && rsp.verdict_hit;
            out_status_next  = tspdf_pkg::STATUS_OK;
            if (is_write && !rsp.key_found && !rsp.has_free)
            begin
                out_status_next = tspdf_pkg::STATUS_FULL;
            end
            else if (is_remove && !rsp.key_found)
            begin
                out_status_next = tspdf_pkg::STATUS_NOT_FOUND;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_verdict_reg <= out_verdict_next;
        out_drop_reg    <= out_drop_next;
        out_status_reg  <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_status_reg, out_drop_reg};
    assign m_axis_tuser  = out_verdict_reg;

    // A status word never carries drop
    a_status_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> !m_axis_tdata[0])
        else $error("status word carries drop");

    // A verdict word carries status ok
    a_verdict_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[2:1] == tspdf_pkg::STATUS_OK))
        else $error("verdict word carries a status");

    // A word that makes a result shows it in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result) |=> m_axis_tvalid)
        else $error("result word lost");

    // An empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the TCP source/port drop filter: streams frame
// bytes and table writes/deletes, predicts every verdict and status word and
// compares them with the result stream. Depends on tspdf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int TBL_DEPTH      = tspdf_pkg::TABLE_ENTRIES_DEFAULT;
    localparam int PHASE_WORDS    = 320;
    localparam int FILL_WORDS     = TBL_DEPTH + 4;
    localparam int KEY_POOL       = 8;
    localparam int PORT_POOL      = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 4;

    // Action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Sender idle and receiver stall percentages per phase
    localparam int SEND_IDLE [PHASES] = '{0, 57, 0, 32};
    localparam int RECV_STALL[PHASES] = '{0, 0, 57, 32};

    typedef enum int {FRAME_GOOD, FRAME_BENT, FRAME_NOISE} frame_kind_e;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  byte_value;
        logic        last_byte;
        logic [31:0] entry_address;
        logic [15:0] entry_port;
    } filter_word_t;

    typedef struct packed {
        logic       is_verdict;
        logic       drop;
        logic [1:0] status;
    } filter_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // byte_value[7:0], entry_address[39:8], entry_port[55:40]
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    logic        s_axis_tlast = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // drop[0], status[2:1], zero[7:3]
    logic [0:0]  m_axis_tuser;        // is_verdict[0]

    filter_word_t   pending_words[$];
    filter_result_t awaited_results[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   words_queued   = 0;
    int   mismatch_count = 0;
    int   stall_cycles   = 0;
    logic word_taken     = 1'b0;
    logic result_taken   = 1'b0;

    // Shadow of the frame capture registers
    logic [5:0]  frm_offset    = '0;
    logic [15:0] frm_ethertype = '0;
    logic [3:0]  frm_version   = '0;
    logic [7:0]  frm_protocol  = '0;
    logic [31:0] frm_src       = '0;
    logic [15:0] frm_dport     = '0;

    // Shadow of the exact-match table
    logic        tbl_valid[TBL_DEPTH];
    logic [31:0] tbl_key  [TBL_DEPTH];
    logic [15:0] tbl_port [TBL_DEPTH];

    // Stimulus pools
    logic [31:0] key_pool [KEY_POOL];
    logic [15:0] port_pool[PORT_POOL];
    logic [31:0] fill_keys[FILL_WORDS];
    logic [31:0] recent_key  = '0;
    logic [15:0] recent_port = '0;
    logic        have_recent = 1'b0;

    tcp_source_port_drop_filter #(
        .TABLE_ENTRIES (TBL_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_port[i]  = '0;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int lookup_slot(input logic [31:0] key);
        for (int i = 0; i < TBL_DEPTH; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    // Advance the shadow state by one accepted word; queue the result it causes
    task automatic apply_filter_word(input logic [1:0] act, input logic [7:0] b,
                                     input logic last, input logic [31:0] addr,
                                     input logic [15:0] port);
        int             slot;
        filter_result_t res;
        res = '0;
        case (act)
            tspdf_pkg::ACT_PACKET:
            begin
                // capture header fields at fixed offsets
                if (frm_offset == tspdf_pkg::OFF_ETHERTYPE_HI ||
                    frm_offset == tspdf_pkg::OFF_ETHERTYPE_LO)
                    frm_ethertype = {frm_ethertype[7:0], b};
                else if (frm_offset == tspdf_pkg::OFF_VERSION)
                    frm_version = b[7:4];
                else if (frm_offset == tspdf_pkg::OFF_PROTOCOL)
                    frm_protocol = b;
                else if (frm_offset >= tspdf_pkg::OFF_SRC_FIRST &&
                         frm_offset <= tspdf_pkg::OFF_SRC_LAST)
                    frm_src = {frm_src[23:0], b};
                else if (frm_offset == tspdf_pkg::OFF_DPORT_HI ||
                         frm_offset == tspdf_pkg::OFF_DPORT_LO)
                    frm_dport = {frm_dport[7:0], b};

                if (last)
                begin
                    res.is_verdict = 1'b1;
                    if (frm_offset >= tspdf_pkg::MIN_LAST_OFFSET &&
                        frm_ethertype == tspdf_pkg::IPV4_ETHERTYPE &&
                        frm_version == tspdf_pkg::IPV4_VERSION &&
                        frm_protocol == tspdf_pkg::TCP_PROTOCOL)
                    begin
                        slot = lookup_slot(frm_src);
                        if (slot >= 0)
                            res.drop = (tbl_port[slot] == frm_dport);
                    end
                    awaited_results.push_back(res);
                    frm_offset    = '0;
                    frm_ethertype = '0;
                    frm_version   = '0;
                    frm_protocol  = '0;
                    frm_src       = '0;
                    frm_dport     = '0;
                end
                else if (frm_offset < tspdf_pkg::OFFSET_MAX)
                    frm_offset = frm_offset + 6'd1;
            end
            tspdf_pkg::ACT_WRITE:
            begin
                // replace by key, else take the lowest free slot
                slot = lookup_slot(addr);
                for (int i = 0; i < TBL_DEPTH; i++)
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                if (slot < 0)
                    res.status = tspdf_pkg::STATUS_FULL;
                else
                begin
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = addr;
                    tbl_port[slot]  = port;
                    res.status      = tspdf_pkg::STATUS_OK;
                end
                awaited_results.push_back(res);
            end
            tspdf_pkg::ACT_REMOVE:
            begin
                slot = lookup_slot(addr);
                if (slot < 0)
                    res.status = tspdf_pkg::STATUS_NOT_FOUND;
                else
                begin
                    tbl_valid[slot] = 1'b0;
                    res.status      = tspdf_pkg::STATUS_OK;
                end
                awaited_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic queue_word(input logic [1:0] act, input logic [7:0] b, input logic last,
                              input logic [31:0] addr, input logic [15:0] port);
        filter_word_t w;
        w.action        = act;
        w.byte_value    = b;
        w.last_byte     = last;
        w.entry_address = addr;
        w.entry_port    = port;
        pending_words.push_back(w);
        if (act != ACT_UNUSED)
            words_queued++;
    endtask

    // Table word with random don't-care byte and last fields
    task automatic queue_table_op(input logic [1:0] act, input logic [31:0] addr,
                                  input logic [15:0] port);
        queue_word(act, 8'($urandom_range(255)), 1'($urandom_range(1)), addr, port);
        if (act == tspdf_pkg::ACT_WRITE)
        begin
            recent_key  = addr;
            recent_port = port;
            have_recent = 1'b1;
        end
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(KEY_POOL - 1)];
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(99) < 80)
            return port_pool[$urandom_range(PORT_POOL - 1)];
        return 16'($urandom_range(65535));
    endfunction

    // Table write, delete or ignored word, as it may land inside a frame
    task automatic queue_side_word();
        case ($urandom_range(2))
            0:       queue_table_op(tspdf_pkg::ACT_WRITE, pick_key(), pick_port());
            1:       queue_table_op(tspdf_pkg::ACT_REMOVE, pick_key(), pick_port());
            default: queue_word(ACT_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                $urandom, 16'($urandom_range(65535)));
        endcase
    endtask

    task automatic queue_frame(input int len, input frame_kind_e kind, input int mix_pct);
        logic [31:0] key;
        logic [15:0] dport;
        logic [7:0]  b;
        logic [5:0]  bent_off;
        key   = pick_key();
        dport = pick_port();
        if (have_recent && $urandom_range(1))
        begin
            key = recent_key;
            if ($urandom_range(99) < 80)
                dport = recent_port;
        end
        case ($urandom_range(3))
            0:       bent_off = tspdf_pkg::OFF_ETHERTYPE_HI;
            1:       bent_off = tspdf_pkg::OFF_ETHERTYPE_LO;
            2:       bent_off = tspdf_pkg::OFF_VERSION;
            default: bent_off = tspdf_pkg::OFF_PROTOCOL;
        endcase
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(255));
            if (kind != FRAME_NOISE)
            begin
                // plant an IPv4/TCP header; a bent frame gets one bit flipped
                if (i == tspdf_pkg::OFF_ETHERTYPE_HI)
                    b = tspdf_pkg::IPV4_ETHERTYPE[15:8];
                else if (i == tspdf_pkg::OFF_ETHERTYPE_LO)
                    b = tspdf_pkg::IPV4_ETHERTYPE[7:0];
                else if (i == tspdf_pkg::OFF_VERSION)
                    b = {tspdf_pkg::IPV4_VERSION, b[3:0]};
                else if (i == tspdf_pkg::OFF_PROTOCOL)
                    b = tspdf_pkg::TCP_PROTOCOL;
                else if (i >= tspdf_pkg::OFF_SRC_FIRST && i <= tspdf_pkg::OFF_SRC_LAST)
                    b = key[8 * (tspdf_pkg::OFF_SRC_LAST - i) +: 8];
                else if (i == tspdf_pkg::OFF_DPORT_HI)
                    b = dport[15:8];
                else if (i == tspdf_pkg::OFF_DPORT_LO)
                    b = dport[7:0];
                if (kind == FRAME_BENT && i == bent_off)
                    b = b ^ ((bent_off == tspdf_pkg::OFF_VERSION)
                             ? (8'h10 << $urandom_range(3))
                             : (8'h01 << $urandom_range(7)));
            end
            if ($urandom_range(99) < mix_pct)
                queue_side_word();
            queue_word(tspdf_pkg::ACT_PACKET, b, i == len - 1, $urandom,
                       16'($urandom_range(65535)));
        end
    endtask

    // Drive input words and receiver ready on the falling edge
    always @(negedge clk)
    begin : drive_words
        filter_word_t w;
        if (rst_n)
        begin
            if (!s_axis_tvalid || word_taken)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    s_axis_tdata  <= {w.entry_port, w.entry_address, w.byte_value};
                    s_axis_tuser  <= w.action;
                    s_axis_tlast  <= w.last_byte;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sample both handshakes on the rising edge: predict, check, watch for hangs
    always @(posedge clk)
    begin : watch_ports
        filter_result_t seen;
        filter_result_t want;
        word_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (word_taken)
            apply_filter_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast,
                              s_axis_tdata[39:8], s_axis_tdata[55:40]);

        result_taken = rst_n && m_axis_tvalid && m_axis_tready;
        if (result_taken)
        begin
            seen.is_verdict = m_axis_tuser[0];
            seen.drop       = m_axis_tdata[0];
            seen.status     = m_axis_tdata[2:1];
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result word with none awaited: verdict %0b %0b %0d",
                                          seen.is_verdict, seen.drop, seen.status));
            else
            begin
                want = awaited_results.pop_front();
                if (seen.is_verdict !== want.is_verdict)
                    report_mismatch($sformatf("is_verdict got %0b want %0b",
                                              seen.is_verdict, want.is_verdict));
                if (seen.drop !== want.drop)
                    report_mismatch($sformatf("drop got %0b want %0b", seen.drop, want.drop));
                if (seen.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              seen.status, want.status));
            end
        end

        if (word_taken || result_taken)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : run_stimulus
        int target;
        int pick;
        int len;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = 16'h1234;
        for (int i = 3; i < PORT_POOL; i++)
            port_pool[i] = 16'($urandom_range(65535));

        // hold reset, release it between edges
        repeat (5) @(negedge clk);
        send_idle_pct  = SEND_IDLE[0];
        recv_stall_pct = RECV_STALL[0];
        rst_n <= 1'b1;

        // directed: key and port extremes, replace, delete hit and miss, ignored code
        queue_table_op(tspdf_pkg::ACT_WRITE, 32'h0000_0000, 16'h0000);
        queue_table_op(tspdf_pkg::ACT_WRITE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_table_op(tspdf_pkg::ACT_WRITE, 32'hFFFF_FFFF, 16'h1234);
        queue_table_op(tspdf_pkg::ACT_REMOVE, 32'h1234_5678, 16'h0000);
        queue_table_op(tspdf_pkg::ACT_REMOVE, 32'h0000_0000, 16'hFFFF);
        queue_table_op(tspdf_pkg::ACT_REMOVE, 32'h0000_0000, 16'h0000);
        queue_word(ACT_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        // one-byte frame, then a short frame with table words in its middle
        queue_word(tspdf_pkg::ACT_PACKET, 8'hFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(tspdf_pkg::ACT_PACKET, 8'h00, 1'b0, 32'h0000_0000, 16'h0000);
        queue_table_op(tspdf_pkg::ACT_WRITE, 32'h0000_0000, 16'h0000);
        queue_word(ACT_UNUSED, 8'h00, 1'b0, 32'h0000_0000, 16'h0000);
        queue_word(tspdf_pkg::ACT_PACKET, 8'hA5, 1'b0, 32'h5A5A_5A5A, 16'hA5A5);
        queue_table_op(tspdf_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 16'h0000);
        queue_word(tspdf_pkg::ACT_PACKET, 8'h5A, 1'b1, 32'hA5A5_A5A5, 16'h5A5A);
        queue_table_op(tspdf_pkg::ACT_WRITE, 32'hFFFF_FFFF, 16'h1234);

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];

            // fill the table past capacity, later empty it again
            if (p == 1)
                for (int i = 0; i < FILL_WORDS; i++)
                begin
                    fill_keys[i] = $urandom;
                    queue_table_op(tspdf_pkg::ACT_WRITE, fill_keys[i],
                                   16'($urandom_range(65535)));
                end
            if (p == 3)
                for (int i = 0; i < FILL_WORDS; i++)
                    queue_table_op(tspdf_pkg::ACT_REMOVE, fill_keys[i],
                                   16'($urandom_range(65535)));

            target = words_queued + PHASE_WORDS;
            while (words_queued < target)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    case ($urandom_range(9))
                        0:       len = 53;
                        1:       len = 54;
                        9:       len = $urandom_range(90, 65);
                        default: len = $urandom_range(64, 55);
                    endcase
                    queue_frame(len, FRAME_GOOD, ($urandom_range(99) < 60) ? 0 : 5);
                end
                else if (pick < 43)
                    queue_frame($urandom_range(64, 54), FRAME_BENT, 3);
                else if (pick < 48)
                    queue_frame($urandom_range(70, 1), FRAME_NOISE, 3);
                else if (pick < 68)
                    queue_table_op(tspdf_pkg::ACT_WRITE, pick_key(), pick_port());
                else if (pick < 88)
                    queue_table_op(tspdf_pkg::ACT_REMOVE, pick_key(), pick_port());
                else if (pick < 92)
                    queue_word(ACT_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                               $urandom, 16'($urandom_range(65535)));
                else
                    queue_table_op(tspdf_pkg::ACT_WRITE, $urandom,
                                   16'($urandom_range(65535)));
            end

            while (pending_words.size() > 0)
                @(posedge clk);
        end

        // wait for the last word and every result, then idle for DRAIN_CYCLES
        while (pending_words.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (awaited_results.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tspdf_pkg.sv
hw/rtl/tspdf_parser.sv
hw/rtl/tspdf_table.sv
hw/rtl/tcp_source_port_drop_filter.sv
tb/tb_top.sv
